// File: hw/rtl/tfm_pkg.sv
`default_nettype none
package tfm_pkg;

    localparam int AXIS_W  = 16;
    localparam int CORD_W  = 32;
    localparam int ZACC_W  = 26;
    localparam int ATAN_W  = 23;
    localparam int TABLE_LEN = 24;

    localparam logic [7:0] FIN_NEUTRAL = 8'd90;
    localparam logic signed [13:0] FIN_LOW  = 14'sd45;
    localparam logic signed [13:0] FIN_HIGH = 14'sd135;
    localparam logic signed [17:0] ANGLE_LIMIT = 18'sd23040;
    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    localparam logic [2:0] REG_OFFSET_X   = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z   = 3'd2;
    localparam logic [2:0] REG_WEIGHT     = 3'd3;
    localparam logic [2:0] REG_DEAD_BAND  = 3'd4;
    localparam logic [2:0] REG_PITCH_GAIN = 3'd5;
    localparam logic [2:0] REG_ROLL_GAIN  = 3'd6;
    localparam logic [2:0] REG_PRESENT    = 3'd7;

    typedef logic signed [AXIS_W-1:0] axis_t;

    // atan(2^-i) in degrees, Q16.16, rounded
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] i);
        logic [ATAN_W-1:0] v;
        begin
            case (i)
                5'd0:  v = 23'd2949120;
                5'd1:  v = 23'd1740967;
                5'd2:  v = 23'd919879;
                5'd3:  v = 23'd466945;
                5'd4:  v = 23'd234379;
                5'd5:  v = 23'd117304;
                5'd6:  v = 23'd58666;
                5'd7:  v = 23'd29335;
                5'd8:  v = 23'd14668;
                5'd9:  v = 23'd7334;
                5'd10: v = 23'd3667;
                5'd11: v = 23'd1833;
                5'd12: v = 23'd917;
                5'd13: v = 23'd458;
                5'd14: v = 23'd229;
                5'd15: v = 23'd115;
                5'd16: v = 23'd57;
                5'd17: v = 23'd29;
                5'd18: v = 23'd14;
                5'd19: v = 23'd7;
                5'd20: v = 23'd4;
                5'd21: v = 23'd2;
                5'd22: v = 23'd1;
                default: v = 23'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tfm_if.sv
`default_nettype none
interface tfm_accel_if;
    logic valid;
    logic ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface tfm_fin_if;
    logic valid;
    logic ready;
    logic [7:0] north_angle;
    logic [7:0] east_angle;
    logic [7:0] south_angle;
    logic [7:0] west_angle;
    logic signed [15:0] pitch_out;
    logic signed [15:0] roll_out;

    modport source (output valid, output north_angle, output east_angle, output south_angle,
                    output west_angle, output pitch_out, output roll_out, input ready);
    modport sink (input valid, input north_angle, input east_angle, input south_angle,
                  input west_angle, input pitch_out, input roll_out, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tilt_filter_fin_mixer.sv
`default_nettype none
// Tilt filter and fin mixer. One accelerometer word in gives one word of four fin
// commands and the filtered pitch and roll out. With the sensor present a word goes
// through squaring on a shared multiplier, bit-pair square root, CORDIC (pitch and
// roll side by side), then filter and gain. With the sensor absent a word goes
// straight to the fin stage with zero angles. A new word is taken as soon as the
// previous one has left the datapath, even if its result still waits in the output
// register.
module tilt_filter_fin_mixer #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    tfm_accel_if.sink        sample,
    tfm_fin_if.source        result
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQUARE = 4'd1;
    localparam logic [3:0] ST_SQRT   = 4'd2;
    localparam logic [3:0] ST_CORDIC = 4'd3;
    localparam logic [3:0] ST_MUL1   = 4'd4;
    localparam logic [3:0] ST_MUL2   = 4'd5;
    localparam logic [3:0] ST_FIN1   = 4'd6;
    localparam logic [3:0] ST_FIN2   = 4'd7;

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    // configuration
    logic signed [15:0] off_x_reg, off_y_reg, off_z_reg;
    logic [8:0]  weight_reg;
    logic [14:0] dead_band_reg;
    logic [11:0] pitch_gain_reg, roll_gain_reg;
    logic        present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg      <= '0;
            off_y_reg      <= '0;
            off_z_reg      <= '0;
            weight_reg     <= 9'd51;
            dead_band_reg  <= 15'd1280;
            pitch_gain_reg <= 12'd256;
            roll_gain_reg  <= 12'd256;
            present_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tfm_pkg::REG_OFFSET_X:   off_x_reg      <= cfg_data;
                tfm_pkg::REG_OFFSET_Y:   off_y_reg      <= cfg_data;
                tfm_pkg::REG_OFFSET_Z:   off_z_reg      <= cfg_data;
                tfm_pkg::REG_WEIGHT:     weight_reg     <= cfg_data[8:0];
                tfm_pkg::REG_DEAD_BAND:  dead_band_reg  <= cfg_data[14:0];
                tfm_pkg::REG_PITCH_GAIN: pitch_gain_reg <= cfg_data[11:0];
                tfm_pkg::REG_ROLL_GAIN:  roll_gain_reg  <= cfg_data[11:0];
                tfm_pkg::REG_PRESENT:    present_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // control
    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    // datapath
    tfm_pkg::axis_t ax_reg, ay_reg, az_reg;
    logic signed [31:0] sq_reg;
    logic [31:0] rad_reg [2];
    logic [18:0] rem_reg [2];
    logic [15:0] root_reg [2];
    logic signed [tfm_pkg::CORD_W-1:0] cx_reg [2];
    logic signed [tfm_pkg::CORD_W-1:0] cy_reg [2];
    logic signed [tfm_pkg::ZACC_W-1:0] cz_reg [2];
    logic        zero_reg [2];
    logic signed [25:0] wprod_reg [2];
    tfm_pkg::axis_t smooth_reg [2];
    tfm_pkg::axis_t angle_reg [2];
    logic signed [28:0] gprod_reg [2];
    logic [7:0] north_reg, east_reg, south_reg, west_reg;
    tfm_pkg::axis_t pitch_out_reg, roll_out_reg;

    // filter
    logic [8:0] w_eff;
    logic signed [17:0] raw18 [2];
    tfm_pkg::axis_t raw [2];
    logic signed [26:0] sum_w [2];
    tfm_pkg::axis_t smooth_new [2];

    logic take;
    assign sample.ready = (state_reg == ST_IDLE);
    assign take = sample.valid && sample.ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (take)
                    state_next = present_reg ? ST_SQUARE : ST_FIN1;
            end
            ST_SQUARE:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    cnt_next   = '0;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_FIN1;
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2:
            begin
                // hold until the previous word has gone
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            smooth_reg[0] <= '0;
            smooth_reg[1] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_MUL2)
            begin
                smooth_reg[0] <= smooth_new[0];
                smooth_reg[1] <= smooth_new[1];
            end
        end
    end

    // squaring on one multiplier: y*y, z*z, x*x
    tfm_pkg::axis_t sq_op;
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_op = ay_reg;
            2'd1:    sq_op = az_reg;
            default: sq_op = ax_reg;
        endcase
    end

    // square root, one result bit per cycle per lane
    logic [18:0] rem_try [2];
    logic [18:0] trial [2];

    // CORDIC step per lane
    logic signed [tfm_pkg::CORD_W-1:0] dx [2];
    logic signed [tfm_pkg::CORD_W-1:0] dy [2];
    logic signed [tfm_pkg::ZACC_W-1:0] at;

    // fin correction
    logic signed [28:0] gadj [2];
    logic signed [12:0] corr [2];
    logic signed [16:0] mag [2];
    logic signed [13:0] plus_v [2];
    logic signed [13:0] minus_v [2];
    logic [7:0] plus_c [2];
    logic [7:0] minus_c [2];

    assign w_eff = (weight_reg > tfm_pkg::WEIGHT_ONE) ? tfm_pkg::WEIGHT_ONE : weight_reg;
    assign at = $signed({3'b000, tfm_pkg::atan_q16(cnt_reg)});

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rem_try[k] = {rem_reg[k][16:0], rad_reg[k][31:30]};
            trial[k]   = {1'b0, root_reg[k], 2'b01};
            dx[k] = cy_reg[k] >>> cnt_reg;
            dy[k] = cx_reg[k] >>> cnt_reg;
            raw18[k] = zero_reg[k] ? 18'sd0 : 18'((cz_reg[k] + 26'sd128) >>> 8);
            if (raw18[k] > tfm_pkg::ANGLE_LIMIT || raw18[k] < -tfm_pkg::ANGLE_LIMIT)
                raw[k] = smooth_reg[k];
            else
                raw[k] = raw18[k][15:0];
            sum_w[k] = 27'(wprod_reg[k])
                     + 27'($signed({1'b0, 9'(tfm_pkg::WEIGHT_ONE - w_eff)}))
                       * 27'(smooth_reg[k])
                     + 27'sd128;
            smooth_new[k] = sum_w[k][23:8];
            // truncate toward zero
            gadj[k] = gprod_reg[k] + (gprod_reg[k][28] ? 29'sd65535 : 29'sd0);
            corr[k] = 13'(gadj[k] >>> 16);
            mag[k]  = angle_reg[k][15] ? -17'(angle_reg[k]) : 17'(angle_reg[k]);
            if (mag[k] < $signed({2'b00, dead_band_reg}))
                corr[k] = '0;
            plus_v[k]  = 14'sd90 + 14'(corr[k]);
            minus_v[k] = 14'sd90 - 14'(corr[k]);
            if (plus_v[k] < tfm_pkg::FIN_LOW)
                plus_c[k] = 8'(tfm_pkg::FIN_LOW);
            else if (plus_v[k] > tfm_pkg::FIN_HIGH)
                plus_c[k] = 8'(tfm_pkg::FIN_HIGH);
            else
                plus_c[k] = plus_v[k][7:0];
            if (minus_v[k] < tfm_pkg::FIN_LOW)
                minus_c[k] = 8'(tfm_pkg::FIN_LOW);
            else if (minus_v[k] > tfm_pkg::FIN_HIGH)
                minus_c[k] = 8'(tfm_pkg::FIN_HIGH);
            else
                minus_c[k] = minus_v[k][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ax_reg <= sample.accel_x - off_x_reg;
                ay_reg <= sample.accel_y - off_y_reg;
                az_reg <= sample.accel_z - off_z_reg;
                angle_reg[0] <= '0;
                angle_reg[1] <= '0;
            end
            ST_SQUARE:
            begin
                sq_reg <= sq_op * sq_op;
                case (cnt_reg[1:0])
                    2'd1:
                    begin
                        rad_reg[0] <= 32'(sq_reg);
                    end
                    2'd2:
                    begin
                        rad_reg[0] <= rad_reg[0] + 32'(sq_reg);
                        rad_reg[1] <= 32'(sq_reg);
                    end
                    2'd3:
                    begin
                        rad_reg[1] <= rad_reg[1] + 32'(sq_reg);
                    end
                    default: ;
                endcase
                rem_reg[0]  <= '0;
                rem_reg[1]  <= '0;
                root_reg[0] <= '0;
                root_reg[1] <= '0;
            end
            ST_SQRT:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    rad_reg[k] <= {rad_reg[k][29:0], 2'b00};
                    if (rem_try[k] >= trial[k])
                    begin
                        rem_reg[k]  <= rem_try[k] - trial[k];
                        root_reg[k] <= {root_reg[k][14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k]  <= rem_try[k];
                        root_reg[k] <= {root_reg[k][14:0], 1'b0};
                    end
                end
                // pitch: atan2(x, |(y,z)|), roll: atan2(y, |(x,z)|)
                cx_reg[0] <= '0;
                cx_reg[1] <= '0;
                cy_reg[0] <= {{4{ax_reg[15]}}, ax_reg, 12'd0};
                cy_reg[1] <= {{4{ay_reg[15]}}, ay_reg, 12'd0};
                cz_reg[0] <= '0;
                cz_reg[1] <= '0;
                zero_reg[0] <= (ax_reg == '0);
                zero_reg[1] <= (ay_reg == '0);
            end
            ST_CORDIC:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    // seed x from the finished root on the first step
                    logic signed [tfm_pkg::CORD_W-1:0] xv;
                    logic signed [tfm_pkg::CORD_W-1:0] dyv;
                    xv  = (cnt_reg == '0) ? $signed({4'd0, root_reg[k], 12'd0}) : cx_reg[k];
                    dyv = (cnt_reg == '0) ? xv : dy[k];
                    if (!cy_reg[k][tfm_pkg::CORD_W-1])
                    begin
                        cx_reg[k] <= xv + dx[k];
                        cy_reg[k] <= cy_reg[k] - dyv;
                        cz_reg[k] <= cz_reg[k] + at;
                    end
                    else
                    begin
                        cx_reg[k] <= xv - dx[k];
                        cy_reg[k] <= cy_reg[k] + dyv;
                        cz_reg[k] <= cz_reg[k] - at;
                    end
                end
            end
            ST_MUL1:
            begin
                wprod_reg[0] <= $signed({1'b0, w_eff}) * raw[0];
                wprod_reg[1] <= $signed({1'b0, w_eff}) * raw[1];
            end
            ST_MUL2:
            begin
                angle_reg[0] <= smooth_new[0];
                angle_reg[1] <= smooth_new[1];
            end
            ST_FIN1:
            begin
                gprod_reg[0] <= angle_reg[0] * $signed({1'b0, pitch_gain_reg});
                gprod_reg[1] <= angle_reg[1] * $signed({1'b0, roll_gain_reg});
            end
            ST_FIN2:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    north_reg     <= plus_c[0];
                    south_reg     <= minus_c[0];
                    east_reg      <= plus_c[1];
                    west_reg      <= minus_c[1];
                    pitch_out_reg <= angle_reg[0];
                    roll_out_reg  <= angle_reg[1];
                end
            end
            default: ;
        endcase
    end

    assign result.valid       = out_valid_reg;
    assign result.north_angle = north_reg;
    assign result.east_angle  = east_reg;
    assign result.south_angle = south_reg;
    assign result.west_angle  = west_reg;
    assign result.pitch_out   = pitch_out_reg;
    assign result.roll_out    = roll_out_reg;

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !sample.ready)
        else $error("word taken while busy");

    a_fin_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.north_angle >= 8'd45 && result.north_angle <= 8'd135
                          && result.west_angle >= 8'd45 && result.west_angle <= 8'd135))
        else $error("fin command out of range");

    a_absent_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !present_reg) |-> (result.pitch_out == '0
                                             && result.north_angle == tfm_pkg::FIN_NEUTRAL))
        else $error("sensor absent but fins not neutral");

endmodule
`default_nettype wire

// File: verif/tilt_filter_fin_mixer_tb.sv
`default_nettype none
module tilt_filter_fin_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS = 1250;

    typedef struct packed {
        logic [7:0]  north;
        logic [7:0]  east;
        logic [7:0]  south;
        logic [7:0]  west;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } fins_t;

    typedef struct {
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        logic        do_cfg;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic        has_known;
        fins_t       known;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    tfm_accel_if sample ();
    tfm_fin_if result ();

    tilt_filter_fin_mixer #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .sample(sample.sink), .result(result.source)
    );

    // predictor state and configuration
    longint off_x, off_y, off_z, weight, dead_band, gain_p, gain_r, present;
    longint pitch_held, roll_held;

    fins_t pending_fins[$];
    int    errors;
    int    words_in, words_out;
    int    src_idle_pct, snk_idle_pct;
    int    quiet_cycles;

    function automatic longint wrap16(longint v);
        logic [15:0] t;
        t = v[15:0];
        return longint'(signed'(t));
    endfunction

    function automatic longint fdiv_pow2(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'd1 << 40;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint atan_step(int i);
        longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
        return t[i];
    endfunction

    function automatic longint tilt_deg(longint a, longint r);
        longint xv, yv, zv, dx, dy;
        xv = r * 4096;
        yv = a * 4096;
        zv = 0;
        if (a == 0) return 0;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = fdiv_pow2(yv, i);
            dy = fdiv_pow2(xv, i);
            if (yv >= 0)
            begin
                xv += dx; yv -= dy; zv += atan_step(i);
            end
            else
            begin
                xv -= dx; yv += dy; zv -= atan_step(i);
            end
        end
        return fdiv_pow2(zv + 128, 8);
    endfunction

    function automatic longint ema(longint raw, longint held);
        longint w;
        w = (weight > 256) ? 256 : weight;
        if (raw > 23040 || raw < -23040) raw = held;
        return fdiv_pow2(w * raw + (256 - w) * held + 128, 8);
    endfunction

    function automatic logic [7:0] fin_cmd(longint ang, longint g, bit plus);
        longint c, v, mag;
        c = 0;
        mag = ang < 0 ? -ang : ang;
        if (mag >= dead_band) c = (ang * g) / 65536;
        v = plus ? 90 + c : 90 - c;
        if (v < 45) v = 45;
        if (v > 135) v = 135;
        return v[7:0];
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            tfm_pkg::REG_OFFSET_X:   off_x = wrap16(val);
            tfm_pkg::REG_OFFSET_Y:   off_y = wrap16(val);
            tfm_pkg::REG_OFFSET_Z:   off_z = wrap16(val);
            tfm_pkg::REG_WEIGHT:     weight = val[8:0];
            tfm_pkg::REG_DEAD_BAND:  dead_band = val[14:0];
            tfm_pkg::REG_PITCH_GAIN: gain_p = val[11:0];
            tfm_pkg::REG_ROLL_GAIN:  gain_r = val[11:0];
            tfm_pkg::REG_PRESENT:    present = val[0];
            default: ;
        endcase
    endfunction

    function automatic fins_t predict_fins(longint ax, longint ay, longint az);
        longint xv, yv, zv, p, r;
        fins_t f;
        p = 0;
        r = 0;
        if (present != 0)
        begin
            xv = wrap16(ax - off_x);
            yv = wrap16(ay - off_y);
            zv = wrap16(az - off_z);
            pitch_held = ema(tilt_deg(xv, isqrt(yv * yv + zv * zv)), pitch_held);
            roll_held = ema(tilt_deg(yv, isqrt(xv * xv + zv * zv)), roll_held);
            p = pitch_held;
            r = roll_held;
        end
        f.north = fin_cmd(p, gain_p, 1);
        f.east = fin_cmd(r, gain_r, 1);
        f.south = fin_cmd(p, gain_p, 0);
        f.west = fin_cmd(r, gain_r, 0);
        f.pitch = p[15:0];
        f.roll = r[15:0];
        return f;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: check each fin word against the oldest prediction
    always @(posedge clk)
    begin
        fins_t got, want;
        if (rst_n && result.valid && result.ready)
        begin
            got = '{result.north_angle, result.east_angle, result.south_angle,
                    result.west_angle, result.pitch_out, result.roll_out};
            words_out++;
            if (pending_fins.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, got);
                errors++;
            end
            else
            begin
                want = pending_fins.pop_front();
                if (got != want)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
        if (rst_n)
            result.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("[tilt_filter_fin_mixer] ERROR");
            $finish;
        end
    end

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic drain_fins();
        sample.valid <= 1'b0;
        while (pending_fins.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_accel(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, bit chk, fins_t known);
        fins_t f;
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.accel_x <= ax;
        sample.accel_y <= ay;
        sample.accel_z <= az;
        @(posedge clk);
        while (!sample.ready) @(posedge clk);
        f = predict_fins(ax, ay, az);
        if (chk && f != known)
        begin
            $display("%0t: table row expected %p actual prediction %p", $time, known, f);
            errors++;
        end
        pending_fins.push_back(f);
        words_in++;
    endtask

    task automatic random_config(bit extreme);
        drain_fins();
        write_reg(tfm_pkg::REG_OFFSET_X,
                  extreme ? 16'h8000 : 16'($urandom_range(0, 3000) - 1500));
        write_reg(tfm_pkg::REG_OFFSET_Y,
                  extreme ? 16'h7fff : 16'($urandom_range(0, 3000) - 1500));
        write_reg(tfm_pkg::REG_OFFSET_Z, 16'($urandom));
        write_reg(tfm_pkg::REG_WEIGHT, 16'($urandom_range(0, 511)));
        write_reg(tfm_pkg::REG_DEAD_BAND,
                  extreme ? 16'd23040 : 16'($urandom_range(0, 32767)));
        write_reg(tfm_pkg::REG_PITCH_GAIN,
                  extreme ? 16'd4095 : 16'($urandom_range(0, 4095)));
        write_reg(tfm_pkg::REG_ROLL_GAIN, 16'($urandom_range(0, 4095)));
        write_reg(tfm_pkg::REG_PRESENT, ($urandom_range(9) != 0) ? 16'd1 : 16'd0);
        cfg_we <= 1'b0;
    endtask

    fins_t neutral = '{8'd90, 8'd90, 8'd90, 8'd90, 16'sd0, 16'sd0};
    row_t dir_rows[$];

    initial
    begin
        row_t row;
        fins_t none;
        none = '0;
        errors = 0;
        words_in = 0;
        words_out = 0;
        quiet_cycles = 0;
        src_idle_pct = 34;
        snk_idle_pct = 68;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample.valid = 1'b0;
        sample.accel_x = '0;
        sample.accel_y = '0;
        sample.accel_z = '0;
        result.ready = 1'b0;
        off_x = 0; off_y = 0; off_z = 0;
        weight = 51; dead_band = 1280; gain_p = 256; gain_r = 256; present = 0;
        pitch_held = 0; roll_held = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: sensor absent gives neutral fins; then extremes
        dir_rows = '{
            '{tfm_pkg::REG_PRESENT, 16'd0, 1'b0, 16'sh7fff, 16'sh8000, 16'sd100, 1'b1, neutral},
            '{tfm_pkg::REG_PRESENT, 16'd0, 1'b0, -16'sd1, 16'sd0, 16'sd0, 1'b1, neutral},
            '{tfm_pkg::REG_PRESENT, 16'd1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, neutral},
            '{tfm_pkg::REG_WEIGHT, 16'd256, 1'b1, 16'sd1000, 16'sd0, 16'sd0, 1'b0, none},
            '{tfm_pkg::REG_WEIGHT, 16'd256, 1'b0, -16'sd1000, 16'sd0, 16'sd0, 1'b0, none},
            '{tfm_pkg::REG_WEIGHT, 16'd511, 1'b1, 16'sd0, 16'sd1000, 16'sd0, 1'b0, none},
            '{tfm_pkg::REG_WEIGHT, 16'd0, 1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, none},
            '{tfm_pkg::REG_WEIGHT, 16'd256, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, none},
            '{tfm_pkg::REG_DEAD_BAND, 16'd0, 1'b1, 16'sd500, 16'sd20, 16'sd1000, 1'b0, none},
            '{tfm_pkg::REG_DEAD_BAND, 16'h7fff, 1'b1, 16'sd500, 16'sd500, 16'sd10, 1'b0, none},
            '{tfm_pkg::REG_DEAD_BAND, 16'd0, 1'b1, 16'sd1, 16'sd0, 16'sd0, 1'b0, none},
            '{tfm_pkg::REG_PITCH_GAIN, 16'd4095, 1'b1, 16'sd3000, -16'sd3000, 16'sd50,
              1'b0, none},
            '{tfm_pkg::REG_ROLL_GAIN, 16'd4095, 1'b1, -16'sd3000, 16'sd3000, 16'sd50,
              1'b0, none},
            '{tfm_pkg::REG_PITCH_GAIN, 16'd0, 1'b1, 16'sd300, 16'sd100, -16'sd400, 1'b0, none},
            '{tfm_pkg::REG_ROLL_GAIN, 16'd0, 1'b1, 16'sd0, 16'sd0, 16'sd4096, 1'b0, none},
            '{tfm_pkg::REG_OFFSET_X, 16'h8000, 1'b1, 16'sh7fff, 16'sd10, 16'sd10, 1'b0, none},
            '{tfm_pkg::REG_OFFSET_Y, 16'h7fff, 1'b1, 16'sd0, 16'sh8000, 16'sd0, 1'b0, none},
            '{tfm_pkg::REG_OFFSET_Z, 16'hffff, 1'b1, 16'sd0, 16'sd0, 16'sh7fff, 1'b0, none},
            '{tfm_pkg::REG_PRESENT, 16'd0, 1'b1, 16'sd1234, 16'sd99, 16'sd1, 1'b1, neutral},
            '{tfm_pkg::REG_PRESENT, 16'd1, 1'b1, 16'sd1234, 16'sd99, 16'sd1, 1'b0, none}
        };
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.do_cfg)
            begin
                drain_fins();
                write_reg(row.reg_idx, row.reg_val);
                cfg_we <= 1'b0;
            end
            send_accel(row.ax, row.ay, row.az, row.has_known, row.known);
        end

        // random phases with changing idling and configuration
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 4)
            begin
                src_idle_pct = 68;
                snk_idle_pct = 34;
            end
            if (ph == 7)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            random_config(ph == 2);
            for (int n = 0; n < RANDOM_WORDS / 10; n++)
            begin
                case ($urandom_range(3))
                    0: send_accel(16'($urandom), 16'($urandom), 16'($urandom), 0, none);
                    default: send_accel(16'($urandom_range(0, 8000) - 4000),
                                        16'($urandom_range(0, 8000) - 4000),
                                        16'($urandom_range(0, 20000) - 2000), 0, none);
                endcase
            end
        end
        drain_fins();

        $display("Sent %0d accelerometer words, checked %0d fin words over ten register settings",
                 words_in, words_out);
        if (errors == 0)
            $display("[tilt_filter_fin_mixer] OK");
        else
            $display("[tilt_filter_fin_mixer] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: tilt_filter_fin_mixer.f
hw/rtl/tfm_pkg.sv
hw/rtl/tfm_if.sv
hw/rtl/tilt_filter_fin_mixer.sv
verif/tilt_filter_fin_mixer_tb.sv
